### sv/laser_stripe_column_centroid_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the laser stripe column centroid core
// Concurrent checks clocked on clock, held off during reset.
// ---------------------------------------------------------------------------
`ifndef LASER_STRIPE_COLUMN_CENTROID_CORE_MACROS_SVH
`define LASER_STRIPE_COLUMN_CENTROID_CORE_MACROS_SVH

// cond holds in the same cycle as trig
`define LSCC_ASSERT_SAME(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// cond holds in the cycle after trig
`define LSCC_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

### sv/lscc_pkg.sv
// ---------------------------------------------------------------------------
// lscc_pkg
// Types and fixed constants shared by the column centroid core and its divider.
// ---------------------------------------------------------------------------
package lscc_pkg;

   localparam int PIX_W      = 8;
   localparam int SUM_W      = 22;
   localparam int HIT_W      = 12;
   localparam int COL_OUT_W  = 11;
   localparam int CENTER_W   = 19;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int SIZE_W     = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd2;

   localparam logic [PIX_W-1:0]  THRESHOLD_RESET = 8'd230;
   localparam logic [SIZE_W-1:0] WIDTH_RESET     = 12'd1280;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 12'd1024;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_PUSH
   } lscc_state_type;

   typedef struct packed {
      logic start;
   } lscc_div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lscc_div_stat_type;

endpackage

### sv/lscc_divider.sv
// ---------------------------------------------------------------------------
// lscc_divider
// Restoring divider, one quotient bit per cycle, for the mean hit row.
// ---------------------------------------------------------------------------
module lscc_divider
   import lscc_pkg::*;
#(
   parameter int DVD_W = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  lscc_div_ctrl_type  ctrl,
   input  logic [DVD_W-1:0]   dividend,
   input  logic [HIT_W-1:0]   divisor,
   output lscc_div_stat_type  stat,
   output logic [DVD_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [HIT_W-1:0]  rem_ff, rem_in;
   logic [HIT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [HIT_W:0]    shifted;
   logic [HIT_W:0]    diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when the divisor fits
         rem_in  = fits ? diff[HIT_W-1:0] : shifted[HIT_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

### sv/laser_stripe_column_centroid_core.sv
// A pixel is accepted, its column entry read at the accept edge and written back in the next cycle.
// Pixels go one at a time: req_stall is high for the read-modify-write on the single column memory.
// A column that reports (last row, hits present) runs the bit-serial divider, then waits in
// the push state to load the output register; the next pixel is taken only after that load,
// which waits while the output word is stalled.
// Reset clears counters, control and config; the column memory is not cleared, row 0 writes it.
// ---------------------------------------------------------------------------
// laser_stripe_column_centroid_core
// Per-column mean row of above-threshold laser pixels over a raster pixel stream.
// ---------------------------------------------------------------------------
`include "laser_stripe_column_centroid_core_macros.svh"

module laser_stripe_column_centroid_core
   import lscc_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int FRAC_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel,
   input  logic                  req_frame_start,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COL_OUT_W-1:0]  rsp_column_index,
   output logic [CENTER_W-1:0]   rsp_center_row,
   output logic [HIT_W-1:0]      rsp_hit_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WCMP_W  = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;
   localparam int HCMP_W  = ((ROW_W > SIZE_W) ? ROW_W : SIZE_W) + 1;
   localparam int ENTRY_W = SUM_W + HIT_W;
   localparam int DVD_W   = SUM_W + FRAC_BITS;

   // configuration
   logic [PIX_W-1:0]  thr_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff    <= csr_wdata[PIX_W-1:0];
            CSR_WIDTH:     width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_HEIGHT:    height_ff <= csr_wdata[SIZE_W-1:0];
            default:       ;
         endcase
      end
   end

   // clamped sizes, as last index
   logic [WCMP_W-1:0] w_ext, w_eff, w_last;
   logic [HCMP_W-1:0] h_ext, h_eff, h_last;

   always_comb begin
      w_ext = WCMP_W'(width_ff);
      h_ext = HCMP_W'(height_ff);
      if (w_ext == '0)
         w_eff = WCMP_W'(1);
      else if (w_ext > WCMP_W'(MAX_WIDTH))
         w_eff = WCMP_W'(MAX_WIDTH);
      else
         w_eff = w_ext;
      if (h_ext == '0)
         h_eff = HCMP_W'(1);
      else if (h_ext > HCMP_W'(MAX_HEIGHT))
         h_eff = HCMP_W'(MAX_HEIGHT);
      else
         h_eff = h_ext;
      w_last = w_eff - 1'b1;
      h_last = h_eff - 1'b1;
   end

   // control
   lscc_state_type    state_ff, state_in;
   lscc_div_ctrl_type div_ctrl;
   lscc_div_stat_type div_stat;
   logic              accept;
   logic              mem_we;
   logic              out_load;
   logic              has_result;

   assign accept = req_valid && !req_stall;

   // raster counters
   logic [COL_W-1:0] col_ff, col_in, col_eff;
   logic [ROW_W-1:0] row_ff, row_in, row_eff;
   logic             last_col, last_row;

   always_comb begin
      col_eff  = req_frame_start ? '0 : col_ff;
      row_eff  = req_frame_start ? '0 : row_ff;
      last_col = WCMP_W'(col_eff) >= w_last;
      last_row = HCMP_W'(row_eff) >= h_last;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_eff + 1'b1;
         end else begin
            col_in = col_eff + 1'b1;
            row_in = row_eff;
         end
      end
   end

   // captured item
   logic [COL_W-1:0] item_col_ff;
   logic [ROW_W-1:0] item_row_ff;
   logic             item_hit_ff;
   logic             item_last_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         item_col_ff  <= col_eff;
         item_row_ff  <= row_eff;
         item_hit_ff  <= req_pixel > thr_ff;
         item_last_ff <= last_row;
      end
   end

   // column memory: {row sum, hit count}
   logic [ENTRY_W-1:0] col_mem [MAX_WIDTH];
   logic [ENTRY_W-1:0] rdata_ff;
   logic [SUM_W-1:0]   sum_upd;
   logic [HIT_W-1:0]   cnt_upd;

   always_ff @(posedge clock) begin
      if (accept)
         rdata_ff <= col_mem[col_eff];
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         col_mem[item_col_ff] <= {sum_upd, cnt_upd};
   end

   always_comb begin
      if (item_row_ff == '0) begin
         // first row overwrites the entry
         sum_upd = '0;
         cnt_upd = HIT_W'(item_hit_ff);
      end else if (item_hit_ff) begin
         sum_upd = rdata_ff[ENTRY_W-1:HIT_W] + SUM_W'(item_row_ff);
         cnt_upd = rdata_ff[HIT_W-1:0] + 1'b1;
      end else begin
         sum_upd = rdata_ff[ENTRY_W-1:HIT_W];
         cnt_upd = rdata_ff[HIT_W-1:0];
      end
      has_result = item_last_ff && (cnt_upd != '0);
   end

   // divider
   logic [DVD_W-1:0] quotient;
   logic [DVD_W-1:0] dividend;

   assign dividend = DVD_W'(sum_upd) << FRAC_BITS;

   lscc_divider #(
      .DVD_W(DVD_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (dividend),
      .divisor  (cnt_upd),
      .stat     (div_stat),
      .quotient (quotient)
   );

   logic [COL_W-1:0] res_col_ff;
   logic [HIT_W-1:0] res_cnt_ff;

   always_ff @(posedge clock) begin
      if (div_ctrl.start) begin
         res_col_ff <= item_col_ff;
         res_cnt_ff <= cnt_upd;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_UPDATE;
         ST_UPDATE: state_in = has_result ? ST_DIVIDE : ST_IDLE;
         ST_DIVIDE: if (div_stat.done) state_in = ST_PUSH;
         ST_PUSH:   if (!rsp_valid || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall      = 1'b1;
      mem_we         = 1'b0;
      div_ctrl.start = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_UPDATE: begin
            mem_we         = 1'b1;
            div_ctrl.start = has_result;
         end
         ST_DIVIDE: ;
         ST_PUSH:   out_load = !rsp_valid || !rsp_stall;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic [CENTER_W-1:0]  rsp_center_ff;
   logic [HIT_W-1:0]     rsp_cnt_ff;
   logic [COL_W+COL_OUT_W-1:0]   col_wide;
   logic [DVD_W+CENTER_W-1:0]    quo_wide;

   assign col_wide = {{COL_OUT_W{1'b0}}, res_col_ff};
   assign quo_wide = {{CENTER_W{1'b0}}, quotient};

   always_comb begin
      if (out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_stall)
         rsp_valid_in = rsp_valid_ff;
      else
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_col_ff    <= col_wide[COL_OUT_W-1:0];
         rsp_center_ff <= quo_wide[CENTER_W-1:0];
         rsp_cnt_ff    <= res_cnt_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_center_row   = rsp_center_ff;
   assign rsp_hit_count    = rsp_cnt_ff;

   `LSCC_ASSERT_SAME(a_upd_accept, state_ff == ST_UPDATE, $past(accept), "update without pixel")
   `LSCC_ASSERT_SAME(a_div_start_idle, div_ctrl.start, !div_stat.busy, "divider restarted")
   `LSCC_ASSERT_SAME(a_div_done_state, div_stat.done, state_ff == ST_DIVIDE, "stray divider done")
   `LSCC_ASSERT_NEXT(a_load_nonzero, out_load, rsp_valid && rsp_hit_count != '0, "empty result")

endmodule

### verif/laser_stripe_column_centroid_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// laser_stripe_column_centroid_core_tb
// Streams grayscale frames into the column centroid core and keeps a
// cycle-free model of the per-column row sums and hit counts. Every center
// the core reports is compared against that model, in order, across zero
// and oversize image sizes, mid-frame resizing, a wide row and a tall
// column, random idle and stall patterns and one long output hold-off.
// ---------------------------------------------------------------------------
module laser_stripe_column_centroid_core_tb
   import lscc_pkg::*;
();

   localparam int MAX_COLS      = 2048;
   localparam int MAX_ROWS      = 2048;
   localparam int COL_IDX_W     = $clog2(MAX_COLS);
   localparam int FRAC          = 8;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 600;
   localparam int DRAIN_LIMIT   = 200000;
   localparam int RANDOM_PIXELS = 750;
   localparam int PRINT_LIMIT   = 50;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } pixel_word_type;

   typedef struct packed {
      logic [COL_OUT_W-1:0] column;
      logic [CENTER_W-1:0]  center;
      logic [HIT_W-1:0]     hits;
   } centroid_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COL_OUT_W-1:0]  rsp_column_index;
   logic [CENTER_W-1:0]   rsp_center_row;
   logic [HIT_W-1:0]      rsp_hit_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   laser_stripe_column_centroid_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_index (rsp_column_index),
      .rsp_center_row   (rsp_center_row),
      .rsp_hit_count    (rsp_hit_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // column model state and its copy of the registers
   logic [SUM_W-1:0]  row_sum_mem [MAX_COLS];
   logic [HIT_W-1:0]  hit_cnt_mem [MAX_COLS];
   int unsigned       row_pos = 0;
   int unsigned       col_pos = 0;
   logic [PIX_W-1:0]  thr_cfg    = THRESHOLD_RESET;
   logic [SIZE_W-1:0] width_cfg  = WIDTH_RESET;
   logic [SIZE_W-1:0] height_cfg = HEIGHT_RESET;

   pixel_word_type pixel_q[$];
   centroid_type   center_q[$];

   int unsigned pixels_queued = 0;
   int unsigned pixels_taken = 0;
   int unsigned centers_checked = 0;
   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_seq = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned gen_width = 32'(WIDTH_RESET);
   bit          grow_start = 1'b0;
   bit          req_fire = 1'b0;

   function automatic int unsigned effective_size(input logic [SIZE_W-1:0] v,
                                                  input int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return 32'(v);
   endfunction

   // one pixel through the column accumulators; queue a center when one is due
   function automatic void accumulate_pixel(input pixel_word_type word);
      int unsigned           w_eff;
      int unsigned           h_eff;
      logic                  hit;
      logic                  last_row;
      logic                  last_col;
      logic [COL_IDX_W-1:0]  c;
      logic [SUM_W-1:0]      s;
      logic [HIT_W-1:0]      k;
      logic [SUM_W+FRAC-1:0] quot;
      centroid_type          res;
      w_eff = effective_size(width_cfg, MAX_COLS);
      h_eff = effective_size(height_cfg, MAX_ROWS);
      hit = word.pixel > thr_cfg;
      if (word.frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      last_row = row_pos >= h_eff - 1;
      last_col = col_pos >= w_eff - 1;
      c = COL_IDX_W'(col_pos);
      if (row_pos == 0) begin
         s = '0;
         k = HIT_W'(hit);
      end else begin
         s = row_sum_mem[c] + (hit ? SUM_W'(row_pos) : '0);
         k = hit_cnt_mem[c] + HIT_W'(hit);
      end
      row_sum_mem[c] = s;
      hit_cnt_mem[c] = k;
      if (last_row && k != 0) begin
         quot = {s, {FRAC{1'b0}}} / k;
         res.column = COL_OUT_W'(col_pos);
         res.center = quot[CENTER_W-1:0];
         res.hits = k;
         center_q.insert(center_q.size(), res);
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   task automatic flag_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("%0t ns  mismatch: %s", $time, what);
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin : monitor
      centroid_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         pixels_taken++;
         accumulate_pixel({req_pixel, req_frame_start});
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (center_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected center word for column %0d",
                                    rsp_column_index));
         end else begin
            want = center_q.pop_front();
            centers_checked++;
            if (rsp_column_index !== want.column)
               flag_mismatch($sformatf("column_index %0d, expected %0d",
                                       rsp_column_index, want.column));
            if (rsp_center_row !== want.center)
               flag_mismatch($sformatf("column %0d center_row %0d, expected %0d",
                                       want.column, rsp_center_row, want.center));
            if (rsp_hit_count !== want.hits)
               flag_mismatch($sformatf("column %0d hit_count %0d, expected %0d",
                                       want.column, rsp_hit_count, want.hits));
         end
      end
   end

   // hold the word until taken, then advance or go idle
   always @(negedge clock) begin : driver
      pixel_word_type word;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            word = pixel_q.pop_front();
            req_valid <= 1'b1;
            req_pixel <= word.pixel;
            req_frame_start <= word.frame_start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : hold_counter
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin : stall_driver
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
   end

   task automatic wait_settled();
      int unsigned spent;
      spent = 0;
      while ((pixels_taken != pixels_queued || center_q.size() != 0) && spent < DRAIN_LIMIT)
      begin
         @(negedge clock);
         spent++;
      end
      if (spent == DRAIN_LIMIT) begin
         flag_mismatch($sformatf("%0d expected centers never arrived", center_q.size()));
         center_q.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_THRESHOLD: thr_cfg = data[PIX_W-1:0];
         CSR_WIDTH:     width_cfg = data;
         CSR_HEIGHT:    height_cfg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drain, then program all three registers
   task automatic configure(input int unsigned thr, input int unsigned w, input int unsigned h);
      logic [CSR_DATA_W-1:0] thr_word;
      int unsigned           w_new;
      wait_settled();
      thr_word = CSR_DATA_W'($urandom);
      thr_word[PIX_W-1:0] = PIX_W'(thr);
      w_new = effective_size(SIZE_W'(w), MAX_COLS);
      // a wider image must restart at row 0 so no unwritten column is read
      if (w_new > gen_width) grow_start = 1'b1;
      gen_width = w_new;
      write_register(CSR_THRESHOLD, thr_word);
      write_register(CSR_WIDTH, CSR_DATA_W'(w));
      write_register(CSR_HEIGHT, CSR_DATA_W'(h));
      @(posedge clock);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 45; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 45; end
         IDLE_BOTH:     begin send_idle_pct = 26; stall_pct = 26; end
         default:       begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   task automatic queue_pixel(input int unsigned pix, input bit start);
      pixel_word_type word;
      word.pixel = PIX_W'(pix);
      word.frame_start = start | grow_start;
      grow_start = 1'b0;
      pixel_q.insert(pixel_q.size(), word);
      pixels_queued++;
   endtask

   function automatic int unsigned pick_pixel(input int unsigned hit_pct);
      int unsigned t;
      t = 32'(thr_cfg);
      if ($urandom_range(99) < 15) return $urandom_range(255, 0);
      if ($urandom_range(99) < hit_pct && t != 255) return $urandom_range(255, t + 1);
      return $urandom_range(t, 0);
   endfunction

   task automatic run_random_phase(input int unsigned phase_no, output int unsigned count);
      int unsigned w;
      int unsigned h;
      int unsigned thr;
      int unsigned hit_pct;
      int unsigned pick;
      int unsigned i;
      pick = $urandom_range(99);
      if (pick < 10) w = 0;
      else if (pick < 75) w = $urandom_range(12, 1);
      else if (pick < 90) w = $urandom_range(64, 13);
      else w = $urandom_range(4095, 65);
      pick = $urandom_range(99);
      if (pick < 10) h = 0;
      else if (w > 64) h = $urandom_range(2, 1);
      else h = $urandom_range(8, 1);
      pick = $urandom_range(99);
      if (pick < 10) thr = 0;
      else if (pick < 20) thr = 255;
      else thr = $urandom_range(255, 0);
      configure(thr, w, h);
      set_idling(idle_mode_type'(phase_no % 4));
      pick = $urandom_range(2);
      hit_pct = (pick == 0) ? 10 : (pick == 1) ? 40 : 80;
      count = $urandom_range(160, 40);
      // mostly whole frames back to back; a stray frame start now and then
      for (i = 0; i < count; i++)
         queue_pixel(pick_pixel(hit_pct),
                     (i == 0) ? ($urandom_range(1) == 1) : ($urandom_range(99) < 3));
   endtask

   initial begin : watchdog
      #8_000_000;
      $display("timeout after %0t ns", $time);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int unsigned random_pixels;
      int unsigned phase_no;
      int unsigned n;
      int unsigned i;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(IDLE_NONE);
      // zero sizes act as a 1x1 image
      configure(0, 0, 0);
      queue_pixel(0, 1'b1);
      queue_pixel(1, 1'b0);
      queue_pixel(255, 1'b1);
      configure(255, 0, 1);
      queue_pixel(255, 1'b0);
      wait_settled();
      write_register(CSR_SPARE, '1);
      // a 3x2 frame, then the first row of a second one without a frame start
      configure(100, 3, 2);
      queue_pixel(200, 1'b1);
      queue_pixel(50, 1'b0);
      queue_pixel(101, 1'b0);
      queue_pixel(200, 1'b0);
      queue_pixel(100, 1'b0);
      queue_pixel(0, 1'b0);
      queue_pixel(101, 1'b0);
      queue_pixel(101, 1'b0);
      queue_pixel(101, 1'b0);
      // stop partway into row 3, then shrink under the counters
      configure(100, 3, 4);
      for (i = 0; i < 8; i++) queue_pixel((i % 3 == 1) ? 150 : 20 + i, i == 0);
      queue_pixel(180, 1'b0);
      queue_pixel(90, 1'b0);
      configure(100, 2, 2);
      queue_pixel(255, 1'b0);
      queue_pixel(101, 1'b0);
      queue_pixel(3, 1'b0);

      // oversize width: the first columns of a single-row image
      set_idling(IDLE_BOTH);
      configure(200, 4095, 1);
      for (i = 0; i < 256; i++)
         queue_pixel((i == 0 || i == 128 || i == 255 || $urandom_range(99) < 3) ?
                     $urandom_range(255, 201) : $urandom_range(200, 0), i == 0);
      // one tall column with hits only near the bottom
      set_idling(IDLE_RECEIVER);
      configure(128, 1, 400);
      for (i = 0; i < 400; i++)
         queue_pixel((i == 399 || (i >= 395 && $urandom_range(1) == 1)) ?
                     $urandom_range(255, 129) : $urandom_range(128, 0), i == 0);

      // every pixel reports; hold the output off so the core backs up
      configure(0, 6, 1);
      set_idling(IDLE_NONE);
      hold_seq++;
      for (i = 0; i < 200; i++) queue_pixel($urandom_range(255, 1), i == 0);

      random_pixels = 0;
      phase_no = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         run_random_phase(phase_no, n);
         random_pixels += n;
         phase_no++;
      end

      wait_settled();
      $display("Streamed %0d pixels; %0d column centers matched across %0d random settings.",
               pixels_taken, centers_checked, phase_no);
      $display("Runs included zero and oversize sizes, mid-frame shrink, a tall column "
               , "and a long hold-off.");
      if (error_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/lscc_pkg.sv
sv/lscc_divider.sv
sv/laser_stripe_column_centroid_core.sv
verif/laser_stripe_column_centroid_core_tb.sv
